[design/kht_pkg.sv]
package kht_pkg;

    localparam int INDEX_BITS_DEF  = 20;
    localparam int MAX_GENOMES_DEF = 256;

    localparam int KMER_W   = 64;
    localparam int GID_W    = 8;
    localparam int OUT_W    = 3;
    localparam int MATCH_W  = 9;
    localparam int HITS_W   = 32;
    localparam int UNIQUE_W = 21;

    // hash multipliers, only the low index bits are ever used
    localparam logic [63:0] HASH_C0 = 64'd1713137323;
    localparam logic [63:0] HASH_C1 = 64'd7341234131;
    localparam logic [63:0] HASH_C2 = 64'd371371377;
    localparam int          HASH_SH1 = 12;
    localparam int          HASH_SH2 = 24;

    localparam logic [UNIQUE_W-1:0] UNIQUE_MAX = {UNIQUE_W{1'b1}};
    localparam logic [HITS_W-1:0]   HITS_MAX   = {HITS_W{1'b1}};

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_OWNED = 2'd1;
    localparam logic [1:0] ST_COLL  = 2'd2;

    localparam logic [OUT_W-1:0] OUT_NEW     = 3'd0;
    localparam logic [OUT_W-1:0] OUT_MADE    = 3'd1;
    localparam logic [OUT_W-1:0] OUT_ALREADY = 3'd2;
    localparam logic [OUT_W-1:0] OUT_HIT     = 3'd3;
    localparam logic [OUT_W-1:0] OUT_MISS    = 3'd4;

    typedef struct packed {
        logic [1:0]        status;
        logic [KMER_W-1:0] key;
        logic [GID_W-1:0]  owner;
        logic [HITS_W-1:0] hits;
    } slot_entry_t;

    typedef struct packed {
        logic [OUT_W-1:0]    outcome;
        logic [MATCH_W-1:0]  match_id;
        logic [HITS_W-1:0]   hit_count;
        logic [UNIQUE_W-1:0] unique_count;
    } result_t;

    typedef struct packed {
        logic                slot_we;
        slot_entry_t         slot_data;
        logic                gen_we;
        logic [UNIQUE_W-1:0] gen_data;
        result_t             res;
    } update_t;

endpackage

[design/kht_ram.sv]
module kht_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/kht_hash.sv]
module kht_hash #(
    parameter int INDEX_BITS = kht_pkg::INDEX_BITS_DEF
) (
    input  logic                      aclk,
    input  logic [kht_pkg::KMER_W-1:0] kmer,
    output logic [INDEX_BITS-1:0]     index
);

    localparam logic [INDEX_BITS-1:0] C0 = kht_pkg::HASH_C0[INDEX_BITS-1:0];
    localparam logic [INDEX_BITS-1:0] C1 = kht_pkg::HASH_C1[INDEX_BITS-1:0];
    localparam logic [INDEX_BITS-1:0] C2 = kht_pkg::HASH_C2[INDEX_BITS-1:0];
    localparam int SH1 = kht_pkg::HASH_SH1;
    localparam int SH2 = kht_pkg::HASH_SH2;

    logic [INDEX_BITS-1:0] op0, op1, op2;
    logic [INDEX_BITS-1:0] p0_next, p1_next, p2_next;
    logic [INDEX_BITS-1:0] p0_reg, p1_reg, p2_reg;
    logic [INDEX_BITS-1:0] index_reg;

    // hash is taken mod 2^INDEX_BITS, so truncated operands suffice
    assign op0 = kmer[INDEX_BITS-1:0];
    assign op1 = kmer[SH1+INDEX_BITS-1:SH1];
    assign op2 = kmer[SH2+INDEX_BITS-1:SH2];

    assign p0_next = INDEX_BITS'(op0 * C0);
    assign p1_next = INDEX_BITS'(op1 * C1);
    assign p2_next = INDEX_BITS'(op2 * C2);

    always_ff @(posedge aclk) begin
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        index_reg <= INDEX_BITS'(p0_reg + p1_reg + p2_reg);
    end

    assign index = index_reg;

endmodule

[design/kht_update.sv]
module kht_update (
    input  logic                          action,
    input  logic [kht_pkg::KMER_W-1:0]    kmer,
    input  logic [kht_pkg::GID_W-1:0]     genome_id,
    input  logic                          gid_ok,
    input  kht_pkg::slot_entry_t          slot,
    input  logic [kht_pkg::UNIQUE_W-1:0]  gen_cnt,
    output kht_pkg::update_t              upd
);

    always_comb begin
        upd = '0;
        upd.slot_data   = slot;
        upd.res.outcome = kht_pkg::OUT_MISS;
        if (action == kht_pkg::ACT_INSERT) begin
            if (gid_ok) begin
                if (slot.status == kht_pkg::ST_EMPTY) begin
                    upd.slot_we          = 1'b1;
                    upd.slot_data.status = kht_pkg::ST_OWNED;
                    upd.slot_data.key    = kmer;
                    upd.slot_data.owner  = genome_id;
                    upd.slot_data.hits   = '0;
                    upd.gen_we           = 1'b1;
                    upd.gen_data         = (gen_cnt == kht_pkg::UNIQUE_MAX) ?
                                           gen_cnt : gen_cnt + 1'b1;
                    upd.res.outcome      = kht_pkg::OUT_NEW;
                    upd.res.unique_count = upd.gen_data;
                end else if (slot.status == kht_pkg::ST_OWNED) begin
                    upd.slot_we          = 1'b1;
                    upd.slot_data.status = kht_pkg::ST_COLL;
                    upd.gen_we           = 1'b1;
                    upd.gen_data         = (gen_cnt == '0) ? gen_cnt : gen_cnt - 1'b1;
                    upd.res.outcome      = kht_pkg::OUT_MADE;
                    upd.res.unique_count = upd.gen_data;
                end else begin
                    upd.res.outcome = kht_pkg::OUT_ALREADY;
                end
            end
        end else if (slot.status == kht_pkg::ST_OWNED && slot.key == kmer) begin
            upd.slot_we        = 1'b1;
            upd.slot_data.hits = (slot.hits == kht_pkg::HITS_MAX) ?
                                 slot.hits : slot.hits + 1'b1;
            upd.res.outcome    = kht_pkg::OUT_HIT;
            upd.res.match_id   = {1'b0, slot.owner} + 1'b1;
            upd.res.hit_count  = upd.slot_data.hits;
        end
    end

endmodule

[design/kmer_hash_table_count.sv]
// flow: an accepted word goes through the two hash stages, the slot read, the genome counter
//   read that hangs off it and the update step before its result word reaches the master side;
//   a new word is taken in the idle state only once the last word has left the update step,
//   and a stalled result holds the update step until the result register can take it
// reset: aresetn low clears control; after release a clearing pass over all 2^INDEX_BITS
//   slots zeroes every slot and genome counter, and s_tready stays low until it ends
module kmer_hash_table_count #(
    parameter int INDEX_BITS  = kht_pkg::INDEX_BITS_DEF,
    parameter int MAX_GENOMES = kht_pkg::MAX_GENOMES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // kmer[63:0], genome_id[71:64]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // match_id[8:0], hit_count[40:9], unique_count[61:41], zero pad
    output logic [2:0]  m_tuser    // outcome
);

    // genome counters only ever see 8-bit ids
    localparam int GEN_DEPTH = (MAX_GENOMES < 256) ? MAX_GENOMES : 256;
    localparam int GEN_AW    = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;
    localparam int SLOT_W    = $bits(kht_pkg::slot_entry_t);

    // controller states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH1 = 3'd2;
    localparam logic [2:0] S_HASH2 = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_SLOT  = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_cnt_reg, clr_cnt_next;

    // accepted word
    logic                          act_reg;
    logic [kht_pkg::KMER_W-1:0]    kmer_reg;
    logic [kht_pkg::GID_W-1:0]     gid_reg;
    logic                          gid_ok;

    logic [INDEX_BITS-1:0] index;

    // memory ports
    logic                  slot_we, slot_re;
    logic [INDEX_BITS-1:0] slot_waddr;
    logic [SLOT_W-1:0]     slot_wdata, slot_rdata;
    logic                  gen_we, gen_re;
    logic [GEN_AW-1:0]     gen_waddr, gen_raddr;
    logic [kht_pkg::UNIQUE_W-1:0] gen_wdata, gen_rdata;

    kht_pkg::slot_entry_t slot_rd;
    kht_pkg::update_t     upd;
    logic                 fire;

    // result register
    logic           m_tvalid_reg, m_tvalid_next;
    kht_pkg::result_t res_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign gid_ok   = (32'(gid_reg) < 32'(MAX_GENOMES));
    assign slot_rd  = kht_pkg::slot_entry_t'(slot_rdata);

    // update commits once the result register can take the word
    assign fire = (state_reg == S_UPD) && (!m_tvalid_reg || m_tready);

    kht_hash #(
        .INDEX_BITS(INDEX_BITS)
    ) u_hash (
        .aclk  (aclk),
        .kmer  (kmer_reg),
        .index (index)
    );

    kht_update u_update (
        .action    (act_reg),
        .kmer      (kmer_reg),
        .genome_id (gid_reg),
        .gid_ok    (gid_ok),
        .slot      (slot_rd),
        .gen_cnt   (gen_rdata),
        .upd       (upd)
    );

    // slot table: status, key, owner and hit count in one word
    kht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (2 ** INDEX_BITS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (index),
        .rdata (slot_rdata)
    );

    // per-genome unique counters
    kht_ram #(
        .WIDTH (kht_pkg::UNIQUE_W),
        .DEPTH (GEN_DEPTH)
    ) u_gen_ram (
        .clk   (aclk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    // memory port steering: clearing sweep or read-modify-write
    always_comb begin
        slot_re    = (state_reg == S_READ);
        gen_re     = (state_reg == S_SLOT);
        slot_we    = 1'b0;
        slot_waddr = index;
        slot_wdata = upd.slot_data;
        gen_we     = 1'b0;
        gen_wdata  = upd.gen_data;
        gen_waddr  = gen_raddr;
        // new owner bumps the inserting genome, a collision hits the former owner
        if (act_reg == kht_pkg::ACT_INSERT && slot_rd.status == kht_pkg::ST_EMPTY) begin
            gen_raddr = gid_reg[GEN_AW-1:0];
        end else begin
            gen_raddr = slot_rd.owner[GEN_AW-1:0];
        end
        if (state_reg == S_CLEAR) begin
            slot_we    = 1'b1;
            slot_waddr = clr_cnt_reg;
            slot_wdata = '0;
            gen_we     = (32'(clr_cnt_reg) < 32'(GEN_DEPTH));
            gen_waddr  = clr_cnt_reg[GEN_AW-1:0];
            gen_wdata  = '0;
        end else if (fire) begin
            slot_we = upd.slot_we;
            gen_we  = upd.gen_we;
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {INDEX_BITS{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_HASH1;
                end
            end
            S_HASH1: state_next = S_HASH2;
            S_HASH2: state_next = S_READ;
            S_READ:  state_next = S_SLOT;
            S_SLOT:  state_next = S_UPD;
            S_UPD: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // output valid: set by a committed update, dropped when taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg  <= s_tuser;
            kmer_reg <= s_tdata[63:0];
            gid_reg  <= s_tdata[71:64];
        end
        if (fire) begin
            res_reg <= upd.res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.outcome;
    assign m_tdata  = {2'b00, res_reg.unique_count, res_reg.hit_count, res_reg.match_id};

    // no word taken while the clearing sweep runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing sweep");

    // table written only by the sweep or a committed update
    a_slot_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_we |-> (state_reg == S_CLEAR || fire))
        else $error("stray slot write");

    // queries never touch genome counters
    a_query_no_gen: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && act_reg == kht_pkg::ACT_QUERY) |-> !gen_we)
        else $error("query wrote a genome counter");

    // a new result only follows the update step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> ($past(state_reg) == S_UPD))
        else $error("result appeared without an update");

    // a hit always names a genome
    a_hit_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && res_reg.outcome == kht_pkg::OUT_HIT) |-> (res_reg.match_id != '0))
        else $error("query hit with zero match id");

endmodule
